### rtl/ccf_pkg.sv
// shared types, operation and status codes for the code cache fetch block
`default_nettype none
package ccf_pkg;

    localparam logic [2:0] OP_FETCH = 3'd0;
    localparam logic [2:0] OP_FILL  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_FILL_REQ    = 3'd1;
    localparam logic [2:0] ST_BYPASS      = 3'd2;
    localparam logic [2:0] ST_FILL_ACCEPT = 3'd3;
    localparam logic [2:0] ST_FILL_DONE   = 3'd4;
    localparam logic [2:0] ST_READ        = 3'd5;
    localparam logic [2:0] ST_WRITTEN     = 3'd6;
    localparam logic [2:0] ST_FLUSHED     = 3'd7;

    localparam logic [2:0] CYC_NONE     = 3'd0;
    localparam logic [2:0] CYC_HIT_FAST = 3'd1;
    localparam logic [2:0] CYC_HIT_SLOW = 3'd2;
    localparam logic [2:0] CYC_EXT_FAST = 3'd5;
    localparam logic [2:0] CYC_EXT_SLOW = 3'd6;

    localparam logic [7:0]  ROM_BANK_MAX   = 8'h5f;
    localparam logic [15:0] LINE_ADDR_MASK = 16'hfff0;

    typedef enum logic [1:0] {
        K_NONE,
        K_NOW,
        K_READ,
        K_WRITE_READ
    } t_kind;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read_pending;
        logic load_byte;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/ccf_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/ccf_ctrl.sv
// sequencing state machine for the code cache fetch block
`default_nettype none
module ccf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ccf_pkg::t_dp_stat i_stat,
    output ccf_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy,
    output logic                   o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PEND_RD,
        S_RDATA
    } t_state;

    t_state r_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (i_stat.kind)
                        ccf_pkg::K_NONE: begin
                            r_state <= S_IDLE;
                        end
                        ccf_pkg::K_NOW: begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                        end
                        ccf_pkg::K_READ: begin
                            r_state <= S_RDATA;
                        end
                        ccf_pkg::K_WRITE_READ: begin
                            r_state <= S_PEND_RD;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_PEND_RD: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy               = (r_state != S_IDLE);
    assign o_strobe             = r_strobe;
    assign o_cmd.capture        = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec           = (r_state == S_EXEC);
    assign o_cmd.read_pending   = (r_state == S_PEND_RD);
    assign o_cmd.load_byte      = (r_state == S_RDATA);

endmodule
`default_nettype wire

### rtl/ccf_datapath.sv
// datapath: captured transaction, valid bits, fill tracking, line store and result registers
`default_nettype none
module ccf_datapath #(
    parameter int CACHE_BYTES = 512,
    parameter int LINE_BYTES  = 16,
    parameter int LINE_COUNT  = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ccf_pkg::t_dp_cmd i_cmd,
    output ccf_pkg::t_dp_stat     o_stat,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_wdata,
    input  wire logic [2:0]       i_opcode,
    input  wire logic [15:0]      i_address,
    input  wire logic [7:0]       i_program_bank,
    input  wire logic [15:0]      i_code_base,
    input  wire logic [7:0]       i_data,
    output logic      [2:0]       o_status,
    output logic      [7:0]       o_byte_out,
    output logic      [23:0]      o_external_address,
    output logic                  o_region,
    output logic      [2:0]       o_cycles
);

    localparam int ADDR_W = $clog2(CACHE_BYTES);
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int LINE_W = $clog2(LINE_COUNT);
    localparam logic [15:0] CACHE_SIZE = 16'(CACHE_BYTES);
    localparam logic [15:0] LINE_LOW   = 16'(LINE_BYTES - 1);
    localparam logic [15:0] LINE_MASK  = ~LINE_LOW & ccf_pkg::LINE_ADDR_MASK;
    localparam logic [OFF_W-1:0] LAST_BYTE = OFF_W'(LINE_BYTES - 1);

    logic [2:0]            r_op;
    logic [15:0]           r_addr;
    logic [7:0]            r_bank;
    logic [15:0]           r_base;
    logic [7:0]            r_data;
    logic                  r_clock_fast;
    logic [LINE_COUNT-1:0] r_valid;
    logic                  r_pending;
    logic [OFF_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_fill_base;
    logic [ADDR_W-1:0]     r_pend_off;
    logic [2:0]            r_status;
    logic [7:0]            r_byte;
    logic [23:0]           r_ext;
    logic                  r_region;
    logic [2:0]            r_cycles;

    logic [LINE_COUNT-1:0] n_valid;
    logic                  n_pending;
    logic [OFF_W-1:0]      n_count;
    logic [ADDR_W-1:0]     n_fill_base;
    logic [ADDR_W-1:0]     n_pend_off;
    logic [2:0]            n_status;
    logic [23:0]           n_ext;
    logic                  n_region;
    logic [2:0]            n_cycles;
    ccf_pkg::t_kind        w_kind;

    logic [15:0]       w_off16;
    logic              w_in_win;
    logic [ADDR_W-1:0] w_off;
    logic [LINE_W-1:0] w_fetch_line;
    logic [15:0]       w_line_base16;
    logic [15:0]       w_src_low;
    logic [15:0]       w_sum16;
    logic [ADDR_W-1:0] w_cache_a;
    logic [15:0]       w_cache_a16;
    logic [LINE_W-1:0] w_write_line;
    logic [15:0]       w_fb16;
    logic [LINE_W-1:0] w_fill_line;
    logic [ADDR_W-1:0] w_fill_a;
    logic              w_fill_last;
    logic [2:0]        w_hit_cyc;
    logic [2:0]        w_ext_cyc;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;

    assign w_off16       = r_addr - r_base;
    assign w_in_win      = (w_off16 < CACHE_SIZE);
    assign w_off         = w_off16[ADDR_W-1:0];
    assign w_fetch_line  = w_off16[OFF_W +: LINE_W];
    assign w_line_base16 = w_off16 & ~LINE_LOW;
    assign w_src_low     = (r_base + w_line_base16) & LINE_MASK;
    assign w_sum16       = r_addr + r_base;
    assign w_cache_a     = w_sum16[ADDR_W-1:0];
    assign w_cache_a16   = 16'(w_cache_a);
    assign w_write_line  = w_cache_a16[OFF_W +: LINE_W];
    assign w_fb16        = 16'(r_fill_base);
    assign w_fill_line   = w_fb16[OFF_W +: LINE_W];
    assign w_fill_a      = r_fill_base + ADDR_W'(r_count);
    assign w_fill_last   = (r_count == LAST_BYTE);
    assign w_hit_cyc     = r_clock_fast ? ccf_pkg::CYC_HIT_FAST : ccf_pkg::CYC_HIT_SLOW;
    assign w_ext_cyc     = r_clock_fast ? ccf_pkg::CYC_EXT_FAST : ccf_pkg::CYC_EXT_SLOW;

    always_comb begin
        n_valid     = r_valid;
        n_pending   = r_pending;
        n_count     = r_count;
        n_fill_base = r_fill_base;
        n_pend_off  = r_pend_off;
        n_status    = ccf_pkg::ST_HIT;
        n_ext       = '0;
        n_region    = 1'b0;
        n_cycles    = ccf_pkg::CYC_NONE;
        w_kind      = ccf_pkg::K_NONE;
        w_we        = 1'b0;
        w_waddr     = w_cache_a;
        unique case (r_op)
            ccf_pkg::OP_FETCH: begin
                n_pending = 1'b0;
                w_kind    = ccf_pkg::K_NOW;
                if (w_in_win) begin
                    if (r_valid[w_fetch_line]) begin
                        n_status = ccf_pkg::ST_HIT;
                        n_cycles = w_hit_cyc;
                        w_kind   = ccf_pkg::K_READ;
                    end else begin
                        n_pending   = 1'b1;
                        n_count     = '0;
                        n_fill_base = w_line_base16[ADDR_W-1:0];
                        n_pend_off  = w_off;
                        n_status    = ccf_pkg::ST_FILL_REQ;
                        n_ext       = {r_bank, w_src_low};
                    end
                end else begin
                    n_status = ccf_pkg::ST_BYPASS;
                    n_ext    = {r_bank, r_addr};
                    n_region = (r_bank > ccf_pkg::ROM_BANK_MAX);
                    n_cycles = w_ext_cyc;
                end
            end
            ccf_pkg::OP_FILL: begin
                if (r_pending) begin
                    w_we     = 1'b1;
                    w_waddr  = w_fill_a;
                    n_cycles = w_ext_cyc;
                    if (w_fill_last) begin
                        n_valid[w_fill_line] = 1'b1;
                        n_pending            = 1'b0;
                        n_count              = '0;
                        n_status             = ccf_pkg::ST_FILL_DONE;
                        w_kind               = ccf_pkg::K_WRITE_READ;
                    end else begin
                        n_count  = r_count + 1'b1;
                        n_status = ccf_pkg::ST_FILL_ACCEPT;
                        w_kind   = ccf_pkg::K_NOW;
                    end
                end
            end
            ccf_pkg::OP_READ: begin
                n_status = ccf_pkg::ST_READ;
                w_kind   = ccf_pkg::K_READ;
            end
            ccf_pkg::OP_WRITE: begin
                w_we     = 1'b1;
                n_status = ccf_pkg::ST_WRITTEN;
                w_kind   = ccf_pkg::K_NOW;
                if (w_cache_a16[OFF_W-1:0] == LAST_BYTE) begin
                    n_valid[w_write_line] = 1'b1;
                end
            end
            ccf_pkg::OP_FLUSH: begin
                n_valid  = '0;
                n_status = ccf_pkg::ST_FLUSHED;
                w_kind   = ccf_pkg::K_NOW;
            end
            default: begin
                w_kind = ccf_pkg::K_NONE;
            end
        endcase
    end

    assign w_raddr = i_cmd.read_pending ? r_pend_off :
                     ((r_op == ccf_pkg::OP_FETCH) ? w_off : w_cache_a);

    ccf_ram #(
        .WIDTH(8),
        .DEPTH(CACHE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.exec && w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_data),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_fast <= 1'b0;
            r_valid      <= '0;
            r_pending    <= 1'b0;
            r_count      <= '0;
            r_fill_base  <= '0;
            r_pend_off   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_clock_fast <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_valid     <= n_valid;
                r_pending   <= n_pending;
                r_count     <= n_count;
                r_fill_base <= n_fill_base;
                r_pend_off  <= n_pend_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_addr <= i_address;
            r_bank <= i_program_bank;
            r_base <= i_code_base;
            r_data <= i_data;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_byte   <= '0;
            r_ext    <= n_ext;
            r_region <= n_region;
            r_cycles <= n_cycles;
        end
        if (i_cmd.load_byte) begin
            r_byte <= w_rdata;
        end
    end

    assign o_stat.kind        = w_kind;
    assign o_status           = r_status;
    assign o_byte_out         = r_byte;
    assign o_external_address = r_ext;
    assign o_region           = r_region;
    assign o_cycles           = r_cycles;

endmodule
`default_nettype wire

### rtl/code_cache_fetch.sv
// top level of the code cache fetch block
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      i_opcode i_address i_program_bank
//                                                  i_code_base i_data
//   result    out        o_strobe, one cycle       o_status o_byte_out o_external_address
//                                                  o_region o_cycles
//   config    in         i_cfg_we                  i_cfg_wdata (clock_fast)
//
// a transaction with no byte to return goes through S_EXEC and shows its result as it
// returns to idle, so the next one can be taken while its result strobe is high
// hits and cache reads also pass S_RDATA to wait on the registered line store read
// the last fill byte writes the store, then reads it back via S_PEND_RD and S_RDATA
// a fill byte with no fill pending, or an unused opcode, gives no result
// a synchronous reset clears the valid bits and the fill state; results cannot be stalled
`default_nettype none
module code_cache_fetch #(
    parameter int CACHE_BYTES = 512,
    parameter int LINE_BYTES  = 16,
    parameter int LINE_COUNT  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_program_bank,
    input  wire logic [15:0] i_code_base,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    output logic             o_strobe,
    output logic      [2:0]  o_status,
    output logic      [7:0]  o_byte_out,
    output logic      [23:0] o_external_address,
    output logic             o_region,
    output logic      [2:0]  o_cycles
);

    ccf_pkg::t_dp_cmd  w_cmd;
    ccf_pkg::t_dp_stat w_stat;

    ccf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_strobe(o_strobe)
    );

    ccf_datapath #(
        .CACHE_BYTES(CACHE_BYTES),
        .LINE_BYTES (LINE_BYTES),
        .LINE_COUNT (LINE_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_address         (i_address),
        .i_program_bank    (i_program_bank),
        .i_code_base       (i_code_base),
        .i_data            (i_data),
        .o_status          (o_status),
        .o_byte_out        (o_byte_out),
        .o_external_address(o_external_address),
        .o_region          (o_region),
        .o_cycles          (o_cycles)
    );

endmodule
`default_nettype wire

### rtl/ccf_checker.sv
// port level checker for the code cache fetch block, bound to the top level
`default_nettype none
module ccf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_byte_out,
    input wire logic [23:0] o_external_address,
    input wire logic        o_region,
    input wire logic [2:0]  o_cycles
);

    a_taken_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction taken but busy not raised");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    a_bypass_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ccf_pkg::ST_BYPASS) |->
            (o_region == (o_external_address[23:16] > ccf_pkg::ROM_BANK_MAX)))
        else $error("bypass region does not match bank");

    a_fill_req_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ccf_pkg::ST_FILL_REQ) |->
            (o_byte_out == 8'd0 && o_cycles == ccf_pkg::CYC_NONE
             && o_external_address[3:0] == 4'd0))
        else $error("fill request fields malformed");

    a_hit_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ccf_pkg::ST_HIT) |->
            (o_cycles == ccf_pkg::CYC_HIT_FAST || o_cycles == ccf_pkg::CYC_HIT_SLOW))
        else $error("hit charged a wrong cycle cost");

endmodule

bind code_cache_fetch ccf_checker u_ccf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_strobe          (o_strobe),
    .o_status          (o_status),
    .o_byte_out        (o_byte_out),
    .o_external_address(o_external_address),
    .o_region          (o_region),
    .o_cycles          (o_cycles)
);
`default_nettype wire

### test/tb_code_cache_fetch.sv
// self-checking testbench for the code cache fetch block: directed and random transactions
module tb_code_cache_fetch;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_BYTES = 512;
    localparam int LINE_BYTES  = 16;
    localparam int LINE_COUNT  = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 6;
    localparam int REPORT_MAX  = 10;

    localparam logic [2:0] OP_SPARE_LO = ccf_pkg::OP_FLUSH + 3'd1;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [7:0]  bank;
        logic [15:0] base;
        logic [7:0]  data;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  byte_v;
        logic [23:0] ext;
        logic        region;
        logic [2:0]  cyc;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [15:0] i_address;
    logic [7:0]  i_program_bank;
    logic [15:0] i_code_base;
    logic [7:0]  i_data;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [7:0]  o_byte_out;
    logic [23:0] o_external_address;
    logic        o_region;
    logic [2:0]  o_cycles;

    // predicted cache state
    logic [7:0] store_mem [CACHE_BYTES];
    bit         written [CACHE_BYTES];
    bit         line_ok [LINE_COUNT];
    bit         fill_on;
    int         fill_cnt;
    logic [8:0] fill_start;
    logic [8:0] fill_want;
    bit         fast_mode;

    t_result     pending_outcomes [$];
    int          outcome_total;
    int          mismatch_count;
    int          report_count;
    bit          steady_run;
    logic [15:0] cur_base;

    code_cache_fetch #(
        .CACHE_BYTES(CACHE_BYTES),
        .LINE_BYTES (LINE_BYTES),
        .LINE_COUNT (LINE_COUNT)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_address         (i_address),
        .i_program_bank    (i_program_bank),
        .i_code_base       (i_code_base),
        .i_data            (i_data),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_byte_out        (o_byte_out),
        .o_external_address(o_external_address),
        .o_region          (o_region),
        .o_cycles          (o_cycles)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_request mk(input logic [2:0] op, input logic [15:0] addr,
                                    input logic [7:0] bank, input logic [15:0] base,
                                    input logic [7:0] data);
        t_request r;
        r.opcode  = op;
        r.address = addr;
        r.bank    = bank;
        r.base    = base;
        r.data    = data;
        return r;
    endfunction

    function automatic bit cache_outcome(input t_request r, output t_result res);
        logic [15:0] off;
        logic [15:0] line_start;
        logic [8:0]  a;
        res = '0;
        case (r.opcode)
            ccf_pkg::OP_FETCH: begin
                off = r.address - r.base;
                fill_on = 1'b0;
                if (off < CACHE_BYTES) begin
                    if (line_ok[off[8:4]]) begin
                        res.status = ccf_pkg::ST_HIT;
                        res.byte_v = store_mem[off[8:0]];
                        res.cyc    = fast_mode ? ccf_pkg::CYC_HIT_FAST
                                               : ccf_pkg::CYC_HIT_SLOW;
                    end else begin
                        line_start = off & ~16'(LINE_BYTES - 1);
                        res.status = ccf_pkg::ST_FILL_REQ;
                        res.ext    = {r.bank,
                                      (r.base + line_start) & ccf_pkg::LINE_ADDR_MASK};
                        fill_on    = 1'b1;
                        fill_cnt   = 0;
                        fill_start = line_start[8:0];
                        fill_want  = off[8:0];
                    end
                end else begin
                    res.status = ccf_pkg::ST_BYPASS;
                    res.ext    = {r.bank, r.address};
                    res.region = r.bank > ccf_pkg::ROM_BANK_MAX;
                    res.cyc    = fast_mode ? ccf_pkg::CYC_EXT_FAST : ccf_pkg::CYC_EXT_SLOW;
                end
                return 1'b1;
            end
            ccf_pkg::OP_FILL: begin
                if (!fill_on) return 1'b0;
                a = fill_start + 9'(fill_cnt);
                store_mem[a] = r.data;
                written[a]   = 1'b1;
                fill_cnt++;
                res.cyc = fast_mode ? ccf_pkg::CYC_EXT_FAST : ccf_pkg::CYC_EXT_SLOW;
                if (fill_cnt >= LINE_BYTES) begin
                    line_ok[fill_start[8:4]] = 1'b1;
                    fill_on    = 1'b0;
                    fill_cnt   = 0;
                    res.status = ccf_pkg::ST_FILL_DONE;
                    res.byte_v = store_mem[fill_want];
                end else begin
                    res.status = ccf_pkg::ST_FILL_ACCEPT;
                end
                return 1'b1;
            end
            ccf_pkg::OP_READ: begin
                a = r.address[8:0] + r.base[8:0];
                res.status = ccf_pkg::ST_READ;
                res.byte_v = store_mem[a];
                return 1'b1;
            end
            ccf_pkg::OP_WRITE: begin
                a = r.address[8:0] + r.base[8:0];
                store_mem[a] = r.data;
                written[a]   = 1'b1;
                if (a[3:0] == 4'(LINE_BYTES - 1)) line_ok[a[8:4]] = 1'b1;
                res.status = ccf_pkg::ST_WRITTEN;
                return 1'b1;
            end
            ccf_pkg::OP_FLUSH: begin
                foreach (line_ok[i]) line_ok[i] = 1'b0;
                res.status = ccf_pkg::ST_FLUSHED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // turn a read of a never-written byte into a write of that byte
    function automatic t_request keep_store_defined(input t_request r);
        logic [15:0] off;
        logic [8:0]  a;
        t_request    q;
        q = r;
        if (r.opcode == ccf_pkg::OP_READ) begin
            a = r.address[8:0] + r.base[8:0];
            if (!written[a]) q.opcode = ccf_pkg::OP_WRITE;
        end else if (r.opcode == ccf_pkg::OP_FETCH) begin
            off = r.address - r.base;
            if (off < CACHE_BYTES && line_ok[off[8:4]] && !written[off[8:0]]) begin
                q.opcode  = ccf_pkg::OP_WRITE;
                q.address = off - r.base;
            end
        end
        return q;
    endfunction

    task automatic send_op(input t_request req);
        t_request r;
        t_result  res;
        r = keep_store_defined(req);
        @(negedge i_clk);
        start          = 1'b1;
        i_opcode       = r.opcode;
        i_address      = r.address;
        i_program_bank = r.bank;
        i_code_base    = r.base;
        i_data         = r.data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cache_outcome(r, res)) begin
            pending_outcomes.push_back(res);
            outcome_total++;
        end
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic pace();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (steady_run || pick < 55) n = 0;
        else if (pick < 90) n = $urandom_range(1, 3);
        else if (pick < 98) n = $urandom_range(4, 12);
        else n = $urandom_range(20, 40);
        if (n > 0) idle_cycles(n);
    endtask

    task automatic wait_all_results();
        idle_cycles(1);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_clock_fast(input bit v);
        wait_all_results();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        fast_mode = v;
    endtask

    function automatic logic [15:0] pick_base();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'hfff0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_request side_op();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return mk(ccf_pkg::OP_FLUSH, 16'($urandom), 8'($urandom), cur_base,
                      8'($urandom));
        else if (pick < 5)
            return mk(ccf_pkg::OP_READ, 16'($urandom), 8'($urandom), cur_base,
                      8'($urandom));
        else
            return mk(ccf_pkg::OP_WRITE, 16'($urandom), 8'($urandom), cur_base,
                      8'($urandom));
    endfunction

    task automatic test_directed_cases();
        int k;
        send_op(mk(ccf_pkg::OP_FILL, 16'h0000, 8'h00, 16'h0000, 8'h12));
        send_op(mk(OP_SPARE_HI, 16'hffff, 8'hff, 16'hffff, 8'hff));
        // last line of a window based at 0xffff
        send_op(mk(ccf_pkg::OP_FETCH, 16'h01fe, 8'h00, 16'hffff, 8'h00));
        for (k = 0; k < 6; k++) begin
            send_op(mk(ccf_pkg::OP_FILL, 16'h0, 8'h0, 16'h0,
                       k == 0 ? 8'h00 : 8'($urandom)));
            pace();
        end
        // flush and line-end write do not cancel the fill
        send_op(mk(ccf_pkg::OP_FLUSH, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_op(mk(ccf_pkg::OP_WRITE, 16'h0040, 8'h00, 16'hffff, 8'hff));
        for (k = 0; k < 10; k++) begin
            send_op(mk(ccf_pkg::OP_FILL, 16'h0, 8'h0, 16'h0,
                       k == 9 ? 8'hff : 8'($urandom)));
            pace();
        end
        send_op(mk(ccf_pkg::OP_FETCH, 16'h01fe, 8'h00, 16'hffff, 8'h00));
        send_op(mk(ccf_pkg::OP_FETCH, 16'hffff, ccf_pkg::ROM_BANK_MAX, 16'h0000, 8'h00));
        send_op(mk(ccf_pkg::OP_FETCH, 16'h0200, ccf_pkg::ROM_BANK_MAX + 8'd1, 16'h0000,
                   8'h00));
        send_op(mk(ccf_pkg::OP_FETCH, 16'h8000, 8'hff, 16'h0000, 8'h00));
        send_op(mk(ccf_pkg::OP_READ, 16'h0040, 8'h00, 16'hffff, 8'h00));
        // a second miss drops the first fill
        send_op(mk(ccf_pkg::OP_FETCH, 16'h0000, 8'hab, 16'h0000, 8'h00));
        send_op(mk(ccf_pkg::OP_FETCH, 16'h0010, 8'h54, 16'h0000, 8'h00));
        send_op(mk(ccf_pkg::OP_FILL, 16'h0000, 8'h00, 16'h0000, 8'h5a));
        pace();
    endtask

    task automatic test_random_traffic(input int n);
        int goal;
        int pick;
        int k;
        goal = outcome_total + n;
        while (outcome_total < goal) begin
            if ($urandom_range(0, 49) == 0) steady_run = !steady_run;
            if ($urandom_range(0, 19) == 0) cur_base = pick_base();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_op(mk(ccf_pkg::OP_FETCH,
                           cur_base + 16'($urandom_range(0, CACHE_BYTES - 1)),
                           8'($urandom), cur_base, 8'($urandom)));
                pace();
                if (fill_on) begin
                    for (k = 0; k < LINE_BYTES; k++) begin
                        if ($urandom_range(0, 99) < 3) break;
                        if ($urandom_range(0, 9) == 0) begin
                            send_op(side_op());
                            pace();
                        end
                        send_op(mk(ccf_pkg::OP_FILL, 16'($urandom), 8'($urandom),
                                   16'($urandom), 8'($urandom)));
                        pace();
                    end
                end
            end else if (pick < 75) begin
                send_op(mk(ccf_pkg::OP_FETCH,
                           cur_base + 16'($urandom_range(0, CACHE_BYTES - 1)),
                           8'($urandom), cur_base, 8'($urandom)));
            end else if (pick < 87) begin
                send_op(side_op());
            end else if (pick < 92) begin
                send_op(mk(ccf_pkg::OP_FETCH, 16'($urandom), 8'($urandom), 16'($urandom),
                           8'($urandom)));
            end else if (pick < 96) begin
                send_op(mk(ccf_pkg::OP_FILL, 16'($urandom), 8'($urandom), 16'($urandom),
                           8'($urandom)));
            end else begin
                send_op(mk(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 16'($urandom),
                           8'($urandom), 16'($urandom), 8'($urandom)));
            end
            pace();
            if ($urandom_range(0, 199) == 0) wait_all_results();
        end
    endtask

    task automatic test_clock_speed();
        set_clock_fast(1'b1);
        test_random_traffic(400);
        set_clock_fast(1'b0);
        test_random_traffic(300);
        set_clock_fast(1'b1);
        test_random_traffic(300);
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_result want;
        bit      bad;
        if (i_rst_n && o_strobe) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (report_count < REPORT_MAX) begin
                    report_count++;
                    $display("unexpected transaction: status %0d byte %h ext %h",
                             o_status, o_byte_out, o_external_address);
                end
            end else begin
                want = pending_outcomes.pop_front();
                bad  = 1'b0;
                if (o_status !== want.status) bad = 1'b1;
                if (o_byte_out !== want.byte_v) bad = 1'b1;
                if (o_external_address !== want.ext) bad = 1'b1;
                if (o_region !== want.region) bad = 1'b1;
                if (o_cycles !== want.cyc) bad = 1'b1;
                if (bad) begin
                    mismatch_count++;
                    if (report_count < REPORT_MAX) begin
                        report_count++;
                        $display("mismatch: exp st %0d byte %h ext %h rg %0d cyc %0d",
                                 want.status, want.byte_v, want.ext, want.region, want.cyc);
                        $display("          got st %0d byte %h ext %h rg %0d cyc %0d",
                                 o_status, o_byte_out, o_external_address, o_region,
                                 o_cycles);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) stall_count = 0;
            else stall_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        start          = 1'b0;
        i_opcode       = ccf_pkg::OP_FETCH;
        i_address      = '0;
        i_program_bank = '0;
        i_code_base    = '0;
        i_data         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        i_rst_n        = 1'b0;
        foreach (store_mem[i]) store_mem[i] = '0;
        foreach (written[i]) written[i] = 1'b0;
        foreach (line_ok[i]) line_ok[i] = 1'b0;
        fill_on        = 1'b0;
        fill_cnt       = 0;
        fill_start     = '0;
        fill_want      = '0;
        fast_mode      = 1'b0;
        outcome_total  = 0;
        mismatch_count = 0;
        report_count   = 0;
        steady_run     = 1'b0;
        cur_base       = 16'h0000;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(500);
        test_clock_speed();

        wait_all_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/ccf_pkg.sv
rtl/ccf_ram.sv
rtl/ccf_ctrl.sv
rtl/ccf_datapath.sv
rtl/code_cache_fetch.sv
rtl/ccf_checker.sv
test/tb_code_cache_fetch.sv
